/* hdl/tpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_pkg: shared types and constants of the triangle pair quad merger
// Face direction codes, fixed field widths and the pair selection record.
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int TOL_W        = 8;
  localparam int FACE_DIR_W   = 3;
  localparam int TRI_VERTS    = 3;
  localparam int QUAD_VERTS   = 4;
  localparam int VIDX_W       = $clog2(TRI_VERTS);
  localparam int BEAT_W       = $clog2(QUAD_VERTS);

  localparam logic [BEAT_W-1:0] QUAD_LAST_BEAT = BEAT_W'(QUAD_VERTS - 1);

  localparam logic [FACE_DIR_W-1:0] DIR_UP    = 3'd0;
  localparam logic [FACE_DIR_W-1:0] DIR_DOWN  = 3'd1;
  localparam logic [FACE_DIR_W-1:0] DIR_POS_Z = 3'd2;
  localparam logic [FACE_DIR_W-1:0] DIR_NEG_Z = 3'd3;
  localparam logic [FACE_DIR_W-1:0] DIR_POS_X = 3'd4;
  localparam logic [FACE_DIR_W-1:0] DIR_NEG_X = 3'd5;

  // How a held triangle and a new one combine into a quad.
  typedef struct packed {
    logic              merged;
    logic [VIDX_W-1:0] ua;
    logic [VIDX_W-1:0] an;
    logic [VIDX_W-1:0] an2;
    logic [VIDX_W-1:0] ub;
    logic              bfirst;
  } tpq_sel_t;

  // Next vertex index around a triangle.
  function automatic logic [VIDX_W-1:0] next3(input logic [VIDX_W-1:0] idx);
    logic [VIDX_W-1:0] r;
    unique case (idx)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/tpq_tri_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_tri_if: triangle input channel
// Valid/ready channel that carries one triangle and the end-of-mesh mark.
// ----------------------------------------------------------------------------
interface tpq_tri_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] v0_x;
  logic signed [COORD_WIDTH-1:0] v0_y;
  logic signed [COORD_WIDTH-1:0] v0_z;
  logic signed [COORD_WIDTH-1:0] v1_x;
  logic signed [COORD_WIDTH-1:0] v1_y;
  logic signed [COORD_WIDTH-1:0] v1_z;
  logic signed [COORD_WIDTH-1:0] v2_x;
  logic signed [COORD_WIDTH-1:0] v2_y;
  logic signed [COORD_WIDTH-1:0] v2_z;
  logic                          mesh_end;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, mesh_end,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, mesh_end,
    output ready
  );
endinterface
`default_nettype wire

/* hdl/tpq_vtx_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_vtx_if: quad vertex output channel
// Valid/ready channel that carries one quad vertex with its face tags.
// ----------------------------------------------------------------------------
interface tpq_vtx_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic [tpq_pkg::FACE_DIR_W-1:0] face_dir;
  logic                          was_merged;
  logic                          quad_last;

  modport source (
    output valid, out_x, out_y, out_z, face_dir, was_merged, quad_last,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, face_dir, was_merged, quad_last,
    output ready
  );
endinterface
`default_nettype wire

/* hdl/tpq_pair_match.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_pair_match: shared vertex search between two triangles
// Finds the matching vertices within tolerance and picks the quad order.
// ----------------------------------------------------------------------------
module tpq_pair_match #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic [3*COORD_WIDTH-1:0]   held_v [tpq_pkg::TRI_VERTS],
  input  wire logic [3*COORD_WIDTH-1:0]   cur_v  [tpq_pkg::TRI_VERTS],
  input  wire logic [tpq_pkg::TOL_W-1:0]  tolerance,
  output tpq_pkg::tpq_sel_t               sel
);

  localparam int VW = tpq_pkg::VIDX_W;

  logic [tpq_pkg::TRI_VERTS-1:0] close_m [tpq_pkg::TRI_VERTS];
  logic [tpq_pkg::TRI_VERTS-1:0] found;
  logic [VW-1:0]                 first_ib [tpq_pkg::TRI_VERTS];
  logic [1:0]                    ns;
  logic [VW-1:0]                 sb0;
  logic [VW-1:0]                 sb1;
  logic [VW-1:0]                 ua;
  logic [VW-1:0]                 ub;
  logic [VW-1:0]                 an;

  // A coordinate pair is close when the magnitude of its difference does not
  // exceed the tolerance.
  function automatic logic coord_close(input logic [COORD_WIDTH-1:0] p,
                                       input logic [COORD_WIDTH-1:0] q,
                                       input logic [tpq_pkg::TOL_W-1:0] tol);
    logic signed [COORD_WIDTH:0] d;
    logic [COORD_WIDTH:0]        mag;
    d   = $signed({p[COORD_WIDTH-1], p}) - $signed({q[COORD_WIDTH-1], q});
    mag = d[COORD_WIDTH] ? (COORD_WIDTH + 1)'(0) - d : d;
    return mag <= {{(COORD_WIDTH + 1 - tpq_pkg::TOL_W){1'b0}}, tol};
  endfunction

  always_comb begin
    for (int ia = 0; ia < tpq_pkg::TRI_VERTS; ia++) begin
      for (int ib = 0; ib < tpq_pkg::TRI_VERTS; ib++) begin
        close_m[ia][ib] =
          coord_close(held_v[ia][COORD_WIDTH-1:0], cur_v[ib][COORD_WIDTH-1:0], tolerance) &&
          coord_close(held_v[ia][2*COORD_WIDTH-1:COORD_WIDTH],
                      cur_v[ib][2*COORD_WIDTH-1:COORD_WIDTH], tolerance) &&
          coord_close(held_v[ia][3*COORD_WIDTH-1:2*COORD_WIDTH],
                      cur_v[ib][3*COORD_WIDTH-1:2*COORD_WIDTH], tolerance);
      end
    end
  end

  // Each held vertex takes the first new vertex that it matches.
  always_comb begin
    for (int ia = 0; ia < tpq_pkg::TRI_VERTS; ia++) begin
      found[ia]    = |close_m[ia];
      first_ib[ia] = '0;
      for (int ib = tpq_pkg::TRI_VERTS - 1; ib >= 0; ib--) begin
        if (close_m[ia][ib]) begin
          first_ib[ia] = VW'(ib);
        end
      end
    end
  end

  always_comb begin
    ns  = '0;
    sb0 = '0;
    sb1 = '0;
    ua  = '0;
    for (int ia = 0; ia < tpq_pkg::TRI_VERTS; ia++) begin
      if (found[ia]) begin
        if (ns == 2'd0) begin
          sb0 = first_ib[ia];
        end else if (ns == 2'd1) begin
          sb1 = first_ib[ia];
        end
        ns = ns + 2'd1;
      end else begin
        ua = VW'(ia);
      end
    end
    ub = '0;
    for (int ib = tpq_pkg::TRI_VERTS - 1; ib >= 0; ib--) begin
      if (VW'(ib) != sb0 && VW'(ib) != sb1) begin
        ub = VW'(ib);
      end
    end
  end

  assign an         = tpq_pkg::next3(ua);
  assign sel.merged = (ns == 2'd2);
  assign sel.ua     = ua;
  assign sel.an     = an;
  assign sel.an2    = tpq_pkg::next3(an);
  assign sel.ub     = ub;
  assign sel.bfirst = close_m[an][tpq_pkg::next3(ub)];

endmodule
`default_nettype wire

/* hdl/triangle_pair_quad_merger.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_pair_quad_merger: pairs triangles into quads and tags face direction
// Merges triangle pairs that share an edge, classifies each quad by its normal
// and streams the quad out as four vertex transactions.
// ----------------------------------------------------------------------------
// Usage:
//   tri_in carries one triangle per transaction. The first triangle of a pair
//   is held; the second resolves the pair into one quad (merged, or the held
//   triangle padded by repeating its third vertex). A triangle that arrives
//   with mesh_end while nothing is held is emitted at once as a padded quad.
//   quad_out carries one quad vertex per transaction, four per quad, with
//   quad_last on the fourth. cfg_wr_en/cfg_wr_data write match_tolerance,
//   which should only change while the block is idle.
// Pipeline:
//   A completed quad moves through the quad, product and output stages in
//   turn; its vertices then leave one per cycle while quad_out.ready stays
//   high. The quad and product stages accept new triangles while the output
//   stage still serializes the last quad, so the output port sets the pace.
// Reset and stalls:
//   rst clears the held flag, the pipeline valids and the tolerance. When the
//   receiver stalls, the vertex stays on quad_out, the two stages behind it
//   fill, and tri_in.ready drops once the quad stage has no room.
// ----------------------------------------------------------------------------
module triangle_pair_quad_merger #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [tpq_pkg::TOL_W-1:0]  cfg_wr_data,
  tpq_tri_if.sink                         tri_in,
  tpq_vtx_if.source                       quad_out
);

  localparam int CW  = COORD_WIDTH;
  localparam int VTW = 3 * CW;       // packed vertex {z, y, x}
  localparam int PW  = 2 * CW + 2;   // product of two coordinate differences
  localparam int NW  = PW + 1;       // one normal component

  typedef logic [VTW-1:0]      vert_t;
  typedef logic signed [CW:0]  diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [NW-1:0] norm_t;

  // Tolerance register.
  logic [tpq_pkg::TOL_W-1:0] match_tolerance;

  // Held triangle; contents are meaningful only while held_valid is set.
  vert_t held_v [tpq_pkg::TRI_VERTS];
  logic  held_valid;
  vert_t cur_v  [tpq_pkg::TRI_VERTS];

  tpq_pkg::tpq_sel_t sel;

  // Quad stage.
  logic  s1_valid;
  vert_t s1_q [tpq_pkg::QUAD_VERTS];
  logic  s1_merged;

  // Product stage.
  logic  s2_valid;
  vert_t s2_q [tpq_pkg::QUAD_VERTS];
  logic  s2_merged;
  prod_t p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  // Output stage, serialized one vertex per transaction.
  logic                           s3_valid;
  vert_t                          s3_q [tpq_pkg::QUAD_VERTS];
  logic                           s3_merged;
  logic [tpq_pkg::FACE_DIR_W-1:0] s3_dir;
  logic [tpq_pkg::BEAT_W-1:0]     beat;

  logic in_fire, out_fire, beat_last;
  logic s1_free, s2_free, s2_load, s3_load;
  logic makes_quad;
  vert_t quad_next [tpq_pkg::QUAD_VERTS];
  logic  merged_next;

  diff_t ux, uy, uz, vx, vy, vz;
  norm_t nx, ny, nz;
  logic [NW-1:0] ax, ay, az;
  logic [tpq_pkg::FACE_DIR_W-1:0] dir_next;

  function automatic vert_t pick3(input vert_t a0, input vert_t a1, input vert_t a2,
                                  input logic [tpq_pkg::VIDX_W-1:0] idx);
    vert_t r;
    unique case (idx)
      2'd0:    r = a0;
      2'd1:    r = a1;
      default: r = a2;
    endcase
    return r;
  endfunction

  function automatic diff_t cdiff(input vert_t a, input vert_t b, input int k);
    logic [CW-1:0] ca, cb;
    ca = a[k*CW +: CW];
    cb = b[k*CW +: CW];
    return $signed({ca[CW-1], ca}) - $signed({cb[CW-1], cb});
  endfunction

  function automatic logic [NW-1:0] nabs(input norm_t n);
    return n[NW-1] ? NW'(0) - n : n;
  endfunction

  function automatic logic npos(input norm_t n);
    return !n[NW-1] && (n != '0);
  endfunction

  // --------------------------------------------------------------------------
  // Handshakes. Each stage loads when the one ahead of it empties or moves on.
  // --------------------------------------------------------------------------
  assign out_fire  = quad_out.valid && quad_out.ready;
  assign beat_last = (beat == tpq_pkg::QUAD_LAST_BEAT);
  assign s3_load   = s2_valid && (!s3_valid || (out_fire && beat_last));
  assign s2_free   = !s2_valid || s3_load;
  assign s2_load   = s1_valid && s2_free;
  assign s1_free   = !s1_valid || s2_load;
  assign tri_in.ready = s1_free;
  assign in_fire   = tri_in.valid && tri_in.ready;

  assign cur_v[0] = {tri_in.v0_z, tri_in.v0_y, tri_in.v0_x};
  assign cur_v[1] = {tri_in.v1_z, tri_in.v1_y, tri_in.v1_x};
  assign cur_v[2] = {tri_in.v2_z, tri_in.v2_y, tri_in.v2_x};

  tpq_pair_match #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_match (
    .held_v    (held_v),
    .cur_v     (cur_v),
    .tolerance (match_tolerance),
    .sel       (sel)
  );

  // --------------------------------------------------------------------------
  // Quad formation. With nothing held, only a mesh_end triangle forms a quad.
  // A held triangle always resolves into a quad, merged or padded.
  // --------------------------------------------------------------------------
  always_comb begin
    makes_quad = held_valid || tri_in.mesh_end;
    if (!held_valid) begin
      quad_next[0] = cur_v[0];
      quad_next[1] = cur_v[1];
      quad_next[2] = cur_v[2];
      quad_next[3] = cur_v[2];
      merged_next  = 1'b0;
    end else if (sel.merged) begin
      quad_next[0] = pick3(held_v[0], held_v[1], held_v[2], sel.ua);
      quad_next[1] = sel.bfirst ? pick3(cur_v[0], cur_v[1], cur_v[2], sel.ub)
                                : pick3(held_v[0], held_v[1], held_v[2], sel.an);
      quad_next[2] = sel.bfirst ? pick3(held_v[0], held_v[1], held_v[2], sel.an)
                                : pick3(cur_v[0], cur_v[1], cur_v[2], sel.ub);
      quad_next[3] = pick3(held_v[0], held_v[1], held_v[2], sel.an2);
      merged_next  = 1'b1;
    end else begin
      quad_next[0] = held_v[0];
      quad_next[1] = held_v[1];
      quad_next[2] = held_v[2];
      quad_next[3] = held_v[2];
      merged_next  = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Normal from the first three quad vertices: u = q2 - q0, v = q1 - q0.
  // The products are registered before the subtraction and comparison.
  // --------------------------------------------------------------------------
  assign ux = cdiff(s1_q[2], s1_q[0], 0);
  assign uy = cdiff(s1_q[2], s1_q[0], 1);
  assign uz = cdiff(s1_q[2], s1_q[0], 2);
  assign vx = cdiff(s1_q[1], s1_q[0], 0);
  assign vy = cdiff(s1_q[1], s1_q[0], 1);
  assign vz = cdiff(s1_q[1], s1_q[0], 2);

  assign nx = p_yz - p_zy;
  assign ny = p_zx - p_xz;
  assign nz = p_xy - p_yx;
  assign ax = nabs(nx);
  assign ay = nabs(ny);
  assign az = nabs(nz);

  // The Y axis wins ties, then X over Z. A zero normal lands on bottom.
  always_comb begin
    priority if (ay >= ax && ay >= az) begin
      dir_next = npos(ny) ? tpq_pkg::DIR_UP : tpq_pkg::DIR_DOWN;
    end else if (ax >= az) begin
      dir_next = npos(nx) ? tpq_pkg::DIR_POS_X : tpq_pkg::DIR_NEG_X;
    end else begin
      dir_next = npos(nz) ? tpq_pkg::DIR_POS_Z : tpq_pkg::DIR_NEG_Z;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= '0;
      held_valid      <= 1'b0;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      s3_valid        <= 1'b0;
      beat            <= '0;
    end else begin
      if (cfg_wr_en) begin
        match_tolerance <= cfg_wr_data;
      end
      if (in_fire) begin
        held_valid <= !held_valid && !tri_in.mesh_end;
      end
      if (in_fire) begin
        s1_valid <= makes_quad;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (s3_load) begin
        s2_valid <= 1'b0;
      end
      if (s3_load) begin
        s3_valid <= 1'b1;
        beat     <= '0;
      end else if (out_fire) begin
        if (beat_last) begin
          s3_valid <= 1'b0;
        end
        beat <= beat + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire && !held_valid && !tri_in.mesh_end) begin
      held_v <= cur_v;
    end
    if (in_fire) begin
      s1_q      <= quad_next;
      s1_merged <= merged_next;
    end
    if (s2_load) begin
      s2_q      <= s1_q;
      s2_merged <= s1_merged;
      p_yz      <= uy * vz;
      p_zy      <= uz * vy;
      p_zx      <= uz * vx;
      p_xz      <= ux * vz;
      p_xy      <= ux * vy;
      p_yx      <= uy * vx;
    end
    if (s3_load) begin
      s3_q      <= s2_q;
      s3_merged <= s2_merged;
      s3_dir    <= dir_next;
    end
  end

  assign quad_out.valid      = s3_valid;
  assign quad_out.out_x      = s3_q[beat][CW-1:0];
  assign quad_out.out_y      = s3_q[beat][2*CW-1:CW];
  assign quad_out.out_z      = s3_q[beat][3*CW-1:2*CW];
  assign quad_out.face_dir   = s3_dir;
  assign quad_out.was_merged = s3_merged;
  assign quad_out.quad_last  = beat_last;

endmodule
`default_nettype wire

/* tb/tb_triangle_pair_quad_merger.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_pair_quad_merger: self-checking bench for the quad merger
// Streams triangles into the merger and predicts every quad vertex from a
// behavioral copy of the pairing, matching and face rules. Checks each vertex
// field by field while the source and the sink idle and stall at random.
// ----------------------------------------------------------------------------
module tb_triangle_pair_quad_merger;

  localparam int CW            = 16;
  localparam int TOL_W         = tpq_pkg::TOL_W;
  localparam int FACE_DIR_W    = tpq_pkg::FACE_DIR_W;
  localparam int TRI_VERTS     = tpq_pkg::TRI_VERTS;
  localparam int QUAD_VERTS    = tpq_pkg::QUAD_VERTS;
  localparam int CMAX          = 2 ** (CW - 1) - 1;
  localparam int CMIN          = -(2 ** (CW - 1));
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 50000;

  // One vertex, one triangle with its end-of-mesh mark, and one quad vertex
  // as it leaves the merger.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vert_t;

  typedef struct packed {
    logic            mesh_end;
    vert_t [2:0]     v;
  } tri_t;

  typedef struct packed {
    vert_t                 p;
    logic [FACE_DIR_W-1:0] dir;
    logic                  merged;
    logic                  last;
  } quad_vtx_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [TOL_W-1:0] cfg_wr_data = '0;

  // Source side: the triangle currently offered and its valid.
  tri_t drv_tri = '0;
  logic drv_valid = 1'b0;
  logic tri_fire = 1'b0;
  // Sink side: ready toward the merger.
  logic sink_ready = 1'b0;

  // Idle and stall rates in percent, and the long sink hold-off request.
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Triangles waiting to be offered, and quad vertices the merger still owes.
  tri_t      triangle_q[$];
  quad_vtx_t quad_vertex_q[$];

  // Predictor state: the matching window and the held first triangle.
  logic [TOL_W-1:0] tolerance = '0;
  tri_t held_tri = '0;
  bit   held_ok = 1'b0;

  int mismatches = 0;
  int vertices_seen = 0;

  tpq_tri_if #(.COORD_WIDTH(CW)) tri_ch ();
  tpq_vtx_if #(.COORD_WIDTH(CW)) quad_ch ();

  triangle_pair_quad_merger #(.COORD_WIDTH(CW)) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tri_in      (tri_ch),
    .quad_out    (quad_ch)
  );

  // The channel payload is driven straight from the registered copy of the
  // offered triangle, so every input is known from time zero.
  assign tri_ch.valid    = drv_valid;
  assign tri_ch.v0_x     = drv_tri.v[0].x;
  assign tri_ch.v0_y     = drv_tri.v[0].y;
  assign tri_ch.v0_z     = drv_tri.v[0].z;
  assign tri_ch.v1_x     = drv_tri.v[1].x;
  assign tri_ch.v1_y     = drv_tri.v[1].y;
  assign tri_ch.v1_z     = drv_tri.v[1].z;
  assign tri_ch.v2_x     = drv_tri.v[2].x;
  assign tri_ch.v2_y     = drv_tri.v[2].y;
  assign tri_ch.v2_z     = drv_tri.v[2].z;
  assign tri_ch.mesh_end = drv_tri.mesh_end;
  assign quad_ch.ready   = sink_ready;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Two vertices are the same when every coordinate lies within the window.
  function automatic bit near(vert_t p, vert_t q);
    int dx, dy, dz, lim;
    dx = int'(p.x) - int'(q.x);
    dy = int'(p.y) - int'(q.y);
    dz = int'(p.z) - int'(q.z);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    lim = int'(tolerance);
    return (dx <= lim) && (dy <= lim) && (dz <= lim);
  endfunction

  // The normal is (c - a) x (b - a). Coordinate differences need 17 bits and
  // their products 34, so 64-bit arithmetic is exact. The dominant axis wins,
  // with Y ahead of X ahead of Z on ties; a zero normal lands on bottom.
  function automatic logic [FACE_DIR_W-1:0] face_of(vert_t a, vert_t b, vert_t c);
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz, ax, ay, az;
    ux = longint'(c.x) - longint'(a.x);
    uy = longint'(c.y) - longint'(a.y);
    uz = longint'(c.z) - longint'(a.z);
    vx = longint'(b.x) - longint'(a.x);
    vy = longint'(b.y) - longint'(a.y);
    vz = longint'(b.z) - longint'(a.z);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    ax = (nx < 0) ? -nx : nx;
    ay = (ny < 0) ? -ny : ny;
    az = (nz < 0) ? -nz : nz;
    if (ay >= ax && ay >= az) return (ny > 0) ? tpq_pkg::DIR_UP : tpq_pkg::DIR_DOWN;
    if (ax >= az) return (nx > 0) ? tpq_pkg::DIR_POS_X : tpq_pkg::DIR_NEG_X;
    return (nz > 0) ? tpq_pkg::DIR_POS_Z : tpq_pkg::DIR_NEG_Z;
  endfunction

  // Queue the four vertices of one quad; all share the face of the first three.
  function automatic void push_quad(vert_t q0, vert_t q1, vert_t q2, vert_t q3,
                                    logic merged);
    vert_t [3:0] q;
    quad_vtx_t e;
    logic [FACE_DIR_W-1:0] dir;
    int k;
    q[0] = q0;
    q[1] = q1;
    q[2] = q2;
    q[3] = q3;
    dir = face_of(q0, q1, q2);
    for (k = 0; k < QUAD_VERTS; k++) begin
      e.p      = q[k];
      e.dir    = dir;
      e.merged = merged;
      e.last   = (k == QUAD_VERTS - 1);
      quad_vertex_q = {quad_vertex_q, e};
    end
  endfunction

  // Expected vertices for one accepted triangle.
  function automatic void merge_triangle(tri_t t);
    int ia, ib, ns, ua, ub, sb0, sb1, an, an2;
    bit found, bfirst;
    if (!held_ok) begin
      // Nothing held: a mesh end goes out at once as a padded quad, anything
      // else waits for its partner.
      if (t.mesh_end) begin
        push_quad(t.v[0], t.v[1], t.v[2], t.v[2], 1'b0);
      end else begin
        held_tri = t;
        held_ok = 1'b1;
      end
      return;
    end
    held_ok = 1'b0;
    ns = 0;
    ua = -1;
    ub = -1;
    sb0 = 0;
    sb1 = 0;
    // Each held vertex claims the first new vertex it matches, so two held
    // vertices may land on the same new one.
    for (ia = 0; ia < TRI_VERTS; ia++) begin
      found = 1'b0;
      for (ib = 0; ib < TRI_VERTS; ib++) begin
        if (!found && near(held_tri.v[ia], t.v[ib])) begin
          if (ns == 0) sb0 = ib;
          else if (ns == 1) sb1 = ib;
          ns++;
          found = 1'b1;
        end
      end
      if (!found) ua = ia;
    end
    for (ib = 0; ib < TRI_VERTS; ib++) begin
      if (ub < 0 && ib != sb0 && ib != sb1) ub = ib;
    end
    // Exactly two shared vertices merge; one, none or all three pad the
    // held triangle and drop the new one.
    if (ns == 2 && ua >= 0 && ub >= 0) begin
      an = (ua + 1) % 3;
      an2 = (ua + 2) % 3;
      bfirst = near(t.v[(ub + 1) % 3], held_tri.v[an]);
      push_quad(held_tri.v[ua],
                bfirst ? t.v[ub] : held_tri.v[an],
                bfirst ? held_tri.v[an] : t.v[ub],
                held_tri.v[an2], 1'b1);
    end else begin
      push_quad(held_tri.v[0], held_tri.v[1], held_tri.v[2], held_tri.v[2], 1'b0);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Source driver: a new triangle transaction is offered at the falling edge
  // once the previous one has been taken, unless this cycle is an idle one.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || tri_fire) begin
      if (triangle_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_tri <= triangle_q.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // A triangle transaction completes at the rising edge with valid and ready
  // both high; the predictor runs on exactly that triangle.
  always @(posedge clk) begin
    tri_fire <= !rst && drv_valid && tri_ch.ready;
    if (!rst && drv_valid && tri_ch.ready) merge_triangle(drv_tri);
  end

  // Long sink hold-off. It is counted here in clock cycles, apart from the
  // random stalls, so the merger backs up and has to drop its input ready.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    sink_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: every vertex transaction is compared with the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic report(input string what);
    mismatches++;
    $display("[%0t] ERROR vertex %0d: %s", $time, vertices_seen, what);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) report($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : check_vertex
    quad_vtx_t want;
    if (!rst && quad_ch.valid && sink_ready) begin
      if (quad_vertex_q.size() == 0) begin
        report("vertex arrived with no quad outstanding");
      end else begin
        want = quad_vertex_q.pop_front();
        check_field("out_x", quad_ch.out_x, want.p.x);
        check_field("out_y", quad_ch.out_y, want.p.y);
        check_field("out_z", quad_ch.out_z, want.p.z);
        check_field("face_dir", quad_ch.face_dir, want.dir);
        check_field("was_merged", quad_ch.was_merged, want.merged);
        check_field("quad_last", quad_ch.quad_last, want.last);
      end
      vertices_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic vert_t mkv(int x, int y, int z);
    vert_t r;
    r.x = CW'(x);
    r.y = CW'(y);
    r.z = CW'(z);
    return r;
  endfunction

  // Coordinates lean toward the range ends, zero and minus one.
  function automatic logic signed [CW-1:0] rnd_coord();
    int pick;
    pick = $urandom_range(11);
    case (pick)
      0: return CW'(CMIN);
      1: return CW'(CMAX);
      2: return '0;
      3: return '1;
      4: return CW'(int'($urandom_range(512)) - 256);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic vert_t rnd_vert();
    vert_t r;
    r.x = rnd_coord();
    r.y = rnd_coord();
    r.z = rnd_coord();
    return r;
  endfunction

  // A vertex on the axis-aligned plane where coordinate axis equals c.
  function automatic vert_t plane_vert(int axis, logic signed [CW-1:0] c);
    vert_t r;
    r = rnd_vert();
    case (axis)
      0: r.x = c;
      1: r.y = c;
      default: r.z = c;
    endcase
    return r;
  endfunction

  // Move a coordinate by d, going the other way if it would leave the range,
  // so the distance to the original is always exactly |d|.
  function automatic logic signed [CW-1:0] shift(logic signed [CW-1:0] c, int d);
    int s;
    s = int'(c) + d;
    if (s > CMAX || s < CMIN) s = int'(c) - d;
    return CW'(s);
  endfunction

  function automatic vert_t nudge(vert_t v, int span);
    vert_t r;
    r.x = shift(v.x, int'($urandom_range(2 * span)) - span);
    r.y = shift(v.y, int'($urandom_range(2 * span)) - span);
    r.z = shift(v.z, int'($urandom_range(2 * span)) - span);
    return r;
  endfunction

  task automatic add_tri(input vert_t p, input vert_t q, input vert_t r, input logic e);
    tri_t t;
    t.v[0] = p;
    t.v[1] = q;
    t.v[2] = r;
    t.mesh_end = e;
    triangle_q = {triangle_q, t};
  endtask

  // One random group: mostly a pair built to share an edge within the window,
  // sometimes a near miss just outside it, all three vertices shared, plain
  // noise, or a lone end-of-mesh triangle. Returns the number of triangles.
  function automatic int add_random_group();
    tri_t a, b;
    vert_t nv, s0, s1;
    int kind, lim, axis, ua, an, an2, slot, rot, d, k;
    bit planar, swap;
    logic signed [CW-1:0] c;
    kind = $urandom_range(99);
    lim = int'(tolerance);
    if (kind < 6) begin
      for (k = 0; k < TRI_VERTS; k++) a.v[k] = rnd_vert();
      a.mesh_end = 1'b1;
      triangle_q = {triangle_q, a};
      return 1;
    end
    // Half of the pairs lie on one axis-aligned plane, like voxel faces.
    axis = $urandom_range(2);
    c = rnd_coord();
    planar = ($urandom_range(1) == 1);
    for (k = 0; k < TRI_VERTS; k++) a.v[k] = planar ? plane_vert(axis, c) : rnd_vert();
    nv = planar ? plane_vert(axis, c) : rnd_vert();
    ua = $urandom_range(2);
    an = (ua + 1) % 3;
    an2 = (ua + 2) % 3;
    slot = $urandom_range(2);
    swap = ($urandom_range(1) == 1);
    s0 = nudge(a.v[an], lim);
    s1 = nudge(a.v[an2], lim);
    if (kind >= 70 && kind < 80) begin
      // One coordinate of one shared vertex sits one unit past the window.
      s1 = a.v[an2];
      d = ($urandom_range(1) == 1) ? lim + 1 : -(lim + 1);
      case ($urandom_range(2))
        0: s1.x = shift(s1.x, d);
        1: s1.y = shift(s1.y, d);
        default: s1.z = shift(s1.z, d);
      endcase
    end
    b.v[slot] = nv;
    b.v[(slot + 1) % 3] = swap ? s1 : s0;
    b.v[(slot + 2) % 3] = swap ? s0 : s1;
    if (kind >= 80 && kind < 86) begin
      rot = $urandom_range(2);
      for (k = 0; k < TRI_VERTS; k++) b.v[k] = nudge(a.v[(k + rot) % 3], lim);
      if (swap) begin
        s0 = b.v[0];
        b.v[0] = b.v[1];
        b.v[1] = s0;
      end
    end else if (kind >= 86) begin
      b.v[(slot + 1) % 3] = rnd_vert();
      if ($urandom_range(1) == 1) b.v[(slot + 2) % 3] = rnd_vert();
    end
    a.mesh_end = 1'b0;
    b.mesh_end = ($urandom_range(3) == 0);
    triangle_q = {triangle_q, a, b};
    return 2;
  endfunction

  // The tolerance register is only written while the merger is idle.
  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    tolerance = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every triangle is taken and every expected vertex is back,
  // then let the pipeline settle in case the last triangle was only held
  // and produced nothing.
  task automatic wait_quiet();
    int waited;
    waited = 0;
    @(negedge clk);
    while ((triangle_q.size() != 0 || drv_valid || quad_vertex_q.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      report($sformatf("%0d vertices still outstanding", quad_vertex_q.size()));
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One random phase. Halfway through the source stops until every vertex
  // owed so far has come back, then carries on.
  task automatic run_phase(input logic [TOL_W-1:0] tol, input int src_pct,
                           input int snk_pct, input int n, input bit long_hold);
    int added;
    write_tolerance(tol);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    if (long_hold) hold_req++;
    added = 0;
    while (added < n / 2) added += add_random_group();
    wait_quiet();
    while (added < n) added += add_random_group();
    wait_quiet();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    vert_t a0, a1, a2, nv, org;
    a0 = mkv(100, 200, 300);
    a1 = mkv(-400, 50, 0);
    a2 = mkv(256, -256, 512);
    nv = mkv(1000, -2000, 3000);
    org = mkv(0, 0, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed cases run with a window of three units.
    write_tolerance(8'd3);
    // A lone end-of-mesh triangle at the coordinate extremes pads at once.
    add_tri(mkv(CMAX, CMIN, CMAX), mkv(CMIN, CMAX, CMIN), mkv(0, -1, 1), 1'b1);
    // Shared edge with the new vertex placed ahead of the held one.
    add_tri(a0, a1, a2, 1'b0);
    add_tri(a2, nv, a1, 1'b0);
    // Shared edge with the new vertex placed after it; mesh end on the
    // second triangle changes nothing.
    add_tri(a0, a1, a2, 1'b0);
    add_tri(a1, nv, a2, 1'b1);
    // One coordinate exactly at the window edge still matches.
    add_tri(a0, a1, a2, 1'b0);
    add_tri(a2, nv, mkv(-400, 50, 3), 1'b0);
    // One unit past the window: no merge.
    add_tri(a0, a1, a2, 1'b0);
    add_tri(a2, nv, mkv(-396, 50, 0), 1'b0);
    // All three vertices shared counts as no merge.
    add_tri(a0, a1, a2, 1'b0);
    add_tri(a1, a2, a0, 1'b0);
    // Two held vertices both land on the same new vertex and still merge.
    add_tri(a0, a1, mkv(-398, 50, 1), 1'b0);
    add_tri(a1, nv, mkv(5, 5, 5), 1'b0);
    // A collinear held triangle has a zero normal and faces bottom.
    add_tri(org, mkv(10, 10, 10), mkv(20, 20, 20), 1'b0);
    add_tri(nv, nv, nv, 1'b0);
    add_tri(a0, a0, a0, 1'b1);
    // Merge across the full coordinate range.
    add_tri(mkv(CMAX, CMAX, CMAX), mkv(CMIN, CMIN, CMIN), mkv(CMAX, CMIN, 0), 1'b0);
    add_tri(mkv(CMIN, CMIN, CMIN), mkv(CMIN, CMAX, CMIN), mkv(CMAX, CMAX, CMAX), 1'b0);
    // Axis-aligned lone triangles, one per face direction.
    add_tri(org, mkv(256, 0, 0), mkv(0, 0, 256), 1'b1);
    add_tri(org, mkv(0, 0, 256), mkv(256, 0, 0), 1'b1);
    add_tri(org, mkv(0, 256, 0), mkv(256, 0, 0), 1'b1);
    add_tri(org, mkv(256, 0, 0), mkv(0, 256, 0), 1'b1);
    add_tri(org, mkv(0, 0, 256), mkv(0, 256, 0), 1'b1);
    add_tri(org, mkv(0, 256, 0), mkv(0, 0, 256), 1'b1);
    wait_quiet();

    // Random phases across the window range and the idle patterns. The first
    // and third open with the long sink hold-off while the source keeps
    // offering triangles.
    run_phase(8'd0, 0, 0, 92, 1'b1);
    run_phase(8'd255, 56, 0, 92, 1'b0);
    run_phase(TOL_W'($urandom_range(255)), 0, 56, 92, 1'b1);
    run_phase(8'd1, 26, 26, 92, 1'b0);
    run_phase(TOL_W'($urandom_range(255)), 0, 0, 92, 1'b0);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* triangle_pair_quad_merger.f */
hdl/tpq_pkg.sv
hdl/tpq_tri_if.sv
hdl/tpq_vtx_if.sv
hdl/tpq_pair_match.sv
hdl/triangle_pair_quad_merger.sv
tb/tb_triangle_pair_quad_merger.sv
